### sv/rfsj_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfsj_pkg
// Types and codes shared by the rectangle forward-scan join unit.
// ----------------------------------------------------------------------------
package rfsj_pkg;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_LOAD_LEFT = 2'd1;
    localparam logic [1:0] MODE_LOAD_RIGHT = 2'd2;
    localparam logic [1:0] MODE_NEXT = 2'd3;

    localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_PAIR = 2'd2;
    localparam logic [1:0] STATUS_DONE = 2'd3;

    localparam logic [1:0] PHASE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_LEFT = 2'd1;
    localparam logic [1:0] PHASE_RIGHT = 2'd2;
    localparam logic [1:0] PHASE_DONE = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] box_min_x;
        logic [15:0] box_min_y;
        logic [15:0] box_max_x;
        logic [15:0] box_max_y;
        logic [15:0] box_id;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] left_id;
        logic [15:0] right_id;
    } out_item_t;

    typedef struct packed {
        logic [15:0] max_y;
        logic [15:0] max_x;
        logic [15:0] min_y;
        logic [15:0] min_x;
        logic [15:0] id;
    } entry_t;

    typedef struct packed {
        logic [1:0] op;
        entry_t     entry;
    } cmd_t;

endpackage

### sv/rfsj_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfsj_fifo
// Two-entry queue of items with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module rfsj_fifo #(
    parameter type DATA_T = logic
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  full,
    input  DATA_T wdata,
    input  logic  pop,
    output logic  empty,
    output DATA_T rdata
);

    DATA_T       store_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        do_push;
    logic        do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = store_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= wdata;
    end

endmodule

### sv/rfsj_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfsj_front
// Accepts input items, turns them into commands and queues them.
// ----------------------------------------------------------------------------
module rfsj_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  rfsj_pkg::in_item_t req,
    output logic              cmd_valid,
    input  logic              cmd_pop,
    output rfsj_pkg::cmd_t    cmd
);

    rfsj_pkg::cmd_t cmd_in;
    logic           cmd_empty;

    always_comb
    begin
        cmd_in.op          = req.mode;
        cmd_in.entry.min_x = req.box_min_x;
        cmd_in.entry.min_y = req.box_min_y;
        cmd_in.entry.max_x = req.box_max_x;
        cmd_in.entry.max_y = req.box_max_y;
        cmd_in.entry.id    = req.box_id;
        if (req.mode == rfsj_pkg::MODE_CLEAR || req.mode == rfsj_pkg::MODE_NEXT)
            cmd_in.entry = '0;
    end

    rfsj_fifo #(
        .DATA_T (rfsj_pkg::cmd_t)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .wdata (cmd_in),
        .pop   (cmd_pop),
        .empty (cmd_empty),
        .rdata (cmd)
    );

    assign cmd_valid = !cmd_empty;

endmodule

### sv/rfsj_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfsj_back
// Box lists and the forward-scan sweep sequencer.
// ----------------------------------------------------------------------------
module rfsj_back #(
    parameter int LIST_CAPACITY = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_pop,
    input  rfsj_pkg::cmd_t      cmd,
    output logic                res_push,
    input  logic                res_full,
    output rfsj_pkg::out_item_t res
);

    localparam int AW = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] CAP = CW'(LIST_CAPACITY);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);

    localparam logic [2:0] S_WAIT   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_CHOOSE = 3'd2;
    localparam logic [2:0] S_INNER  = 3'd3;
    localparam logic [2:0] S_CHECK  = 3'd4;

    rfsj_pkg::entry_t left_mem  [LIST_CAPACITY];
    rfsj_pkg::entry_t right_mem [LIST_CAPACITY];
    rfsj_pkg::entry_t left_rd_reg;
    rfsj_pkg::entry_t right_rd_reg;
    rfsj_pkg::entry_t outer_reg;
    rfsj_pkg::entry_t outer_next;
    rfsj_pkg::entry_t cand;

    logic [2:0]    state_reg, state_next;
    logic [1:0]    phase_reg, phase_next;
    logic [CW-1:0] left_count_reg, left_count_next;
    logic [CW-1:0] right_count_reg, right_count_next;
    logic [CW-1:0] left_cursor_reg, left_cursor_next;
    logic [CW-1:0] right_cursor_reg, right_cursor_next;
    logic [CW-1:0] inner_cursor_reg, inner_cursor_next;
    logic [CW-1:0] other_count;
    logic          left_we, right_we;
    logic [AW-1:0] left_raddr, right_raddr;
    logic          y_hit;

    assign cand = (phase_reg == rfsj_pkg::PHASE_LEFT) ? right_rd_reg : left_rd_reg;
    assign other_count = (phase_reg == rfsj_pkg::PHASE_LEFT) ? right_count_reg
                                                             : left_count_reg;
    assign y_hit = !(outer_reg.max_y < cand.min_y || outer_reg.min_y > cand.max_y);

    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        left_count_next   = left_count_reg;
        right_count_next  = right_count_reg;
        left_cursor_next  = left_cursor_reg;
        right_cursor_next = right_cursor_reg;
        inner_cursor_next = inner_cursor_reg;
        outer_next        = outer_reg;
        cmd_pop           = 1'b0;
        res_push          = 1'b0;
        res               = '0;
        left_we           = 1'b0;
        right_we          = 1'b0;
        left_raddr        = inner_cursor_reg[AW-1:0];
        right_raddr       = inner_cursor_reg[AW-1:0];

        case (state_reg)
            S_WAIT:
            begin
                if (cmd_valid && !res_full)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.op == rfsj_pkg::MODE_NEXT)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        res_push          = 1'b1;
                        res.status        = rfsj_pkg::STATUS_ACCEPTED;
                        left_cursor_next  = '0;
                        right_cursor_next = '0;
                        inner_cursor_next = '0;
                        phase_next        = rfsj_pkg::PHASE_IDLE;
                        if (cmd.op == rfsj_pkg::MODE_CLEAR)
                        begin
                            left_count_next  = '0;
                            right_count_next = '0;
                        end
                        else if (cmd.op == rfsj_pkg::MODE_LOAD_LEFT)
                        begin
                            if (left_count_reg >= CAP)
                                res.status = rfsj_pkg::STATUS_FULL;
                            else
                            begin
                                left_we         = 1'b1;
                                left_count_next = left_count_reg + CNT_ONE;
                            end
                        end
                        else
                        begin
                            if (right_count_reg >= CAP)
                                res.status = rfsj_pkg::STATUS_FULL;
                            else
                            begin
                                right_we         = 1'b1;
                                right_count_next = right_count_reg + CNT_ONE;
                            end
                        end
                    end
                end
            end
            S_SCAN:
            begin
                left_raddr  = left_cursor_reg[AW-1:0];
                right_raddr = right_cursor_reg[AW-1:0];
                case (phase_reg)
                    rfsj_pkg::PHASE_IDLE:
                    begin
                        if (left_cursor_reg >= left_count_reg ||
                            right_cursor_reg >= right_count_reg)
                            phase_next = rfsj_pkg::PHASE_DONE;
                        else
                            state_next = S_CHOOSE;
                    end
                    rfsj_pkg::PHASE_DONE:
                    begin
                        res_push   = 1'b1;
                        res.status = rfsj_pkg::STATUS_DONE;
                        state_next = S_WAIT;
                    end
                    default:
                    begin
                        state_next = S_INNER;
                    end
                endcase
            end
            S_CHOOSE:
            begin
                if (left_rd_reg.min_x <= right_rd_reg.min_x)
                begin
                    phase_next        = rfsj_pkg::PHASE_LEFT;
                    inner_cursor_next = right_cursor_reg;
                    outer_next        = left_rd_reg;
                end
                else
                begin
                    phase_next        = rfsj_pkg::PHASE_RIGHT;
                    inner_cursor_next = left_cursor_reg;
                    outer_next        = right_rd_reg;
                end
                state_next = S_INNER;
            end
            S_INNER:
            begin
                if (inner_cursor_reg < other_count)
                    state_next = S_CHECK;
                else
                begin
                    if (phase_reg == rfsj_pkg::PHASE_LEFT)
                        left_cursor_next = left_cursor_reg + CNT_ONE;
                    else
                        right_cursor_next = right_cursor_reg + CNT_ONE;
                    phase_next = rfsj_pkg::PHASE_IDLE;
                    state_next = S_SCAN;
                end
            end
            S_CHECK:
            begin
                if (outer_reg.max_x >= cand.min_x)
                begin
                    inner_cursor_next = inner_cursor_reg + CNT_ONE;
                    if (y_hit)
                    begin
                        res_push   = 1'b1;
                        res.status = rfsj_pkg::STATUS_PAIR;
                        if (phase_reg == rfsj_pkg::PHASE_LEFT)
                        begin
                            res.left_id  = outer_reg.id;
                            res.right_id = cand.id;
                        end
                        else
                        begin
                            res.left_id  = cand.id;
                            res.right_id = outer_reg.id;
                        end
                        state_next = S_WAIT;
                    end
                    else
                        state_next = S_INNER;
                end
                else
                begin
                    if (phase_reg == rfsj_pkg::PHASE_LEFT)
                        left_cursor_next = left_cursor_reg + CNT_ONE;
                    else
                        right_cursor_next = right_cursor_reg + CNT_ONE;
                    phase_next = rfsj_pkg::PHASE_IDLE;
                    state_next = S_SCAN;
                end
            end
            default:
            begin
                state_next = S_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_WAIT;
            phase_reg        <= rfsj_pkg::PHASE_IDLE;
            left_count_reg   <= '0;
            right_count_reg  <= '0;
            left_cursor_reg  <= '0;
            right_cursor_reg <= '0;
            inner_cursor_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            left_count_reg   <= left_count_next;
            right_count_reg  <= right_count_next;
            left_cursor_reg  <= left_cursor_next;
            right_cursor_reg <= right_cursor_next;
            inner_cursor_reg <= inner_cursor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        outer_reg <= outer_next;
    end

    always_ff @(posedge clk)
    begin
        if (left_we)
            left_mem[left_count_reg[AW-1:0]] <= cmd.entry;
        left_rd_reg <= left_mem[left_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (right_we)
            right_mem[right_count_reg[AW-1:0]] <= cmd.entry;
        right_rd_reg <= right_mem[right_raddr];
    end

endmodule

### sv/rect_forward_scan_join_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_forward_scan_join_unit
// Forward-scan plane-sweep join of two box lists, queue interfaces both sides.
// ----------------------------------------------------------------------------
// Clear and load items can follow one per cycle while the result queue has
// room; each result enters the result queue in the cycle its command is taken.
// A next item resumes the sweep: it picks the list head with the lower min_x as
// outer box, reads candidates one at a time, moves on when a scan runs off a list
// and stops at a pair or done. Each list has a single registered read port.
// Reset empties both lists, restarts the sweep and empties both queues.
module rect_forward_scan_join_unit #(
    parameter int LIST_CAPACITY = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  rfsj_pkg::in_item_t  req,
    output logic                empty,
    input  logic                pop,
    output rfsj_pkg::out_item_t rsp
);

    rfsj_pkg::cmd_t      cmd;
    rfsj_pkg::out_item_t res;
    logic                cmd_valid;
    logic                cmd_pop;
    logic                res_push;
    logic                res_full;

    rfsj_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    rfsj_back #(
        .LIST_CAPACITY (LIST_CAPACITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .res_push  (res_push),
        .res_full  (res_full),
        .res       (res)
    );

    rfsj_fifo #(
        .DATA_T (rfsj_pkg::out_item_t)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .wdata (res),
        .pop   (pop),
        .empty (empty),
        .rdata (rsp)
    );

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rectangle forward-scan join unit. A directed
// table covers clear, extreme boxes, ties, inverted and unsorted boxes and the
// done state. Random load-and-sweep sequences with some inverted boxes follow,
// mixed with noise and interrupted sweeps. Every result is checked against the
// table or a sweep model, under random gaps, stalls and one long output hold.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CAP = 256;
    localparam int IW = $clog2(CAP);

    typedef struct packed {
        rfsj_pkg::in_item_t  item;
        logic                has_exp;
        rfsj_pkg::out_item_t exp;
    } row_t;

    logic                clk;
    logic                rst_n;
    logic                push;
    logic                full;
    rfsj_pkg::in_item_t  req;
    logic                empty;
    logic                pop;
    rfsj_pkg::out_item_t rsp;

    rfsj_pkg::in_item_t left_list [CAP];
    rfsj_pkg::in_item_t right_list [CAP];
    int        left_cnt, right_cnt, left_cur, right_cur, inner_cur;
    logic [1:0] phase;

    rfsj_pkg::out_item_t expected_q [$];
    row_t      dir_rows [$];
    int        errors = 0;
    int        items_sent = 0;
    int        pairs_seen = 0;
    int        dropped_seen = 0;
    bit        calm = 0;
    bit        hold_request = 0;

    rect_forward_scan_join_unit #(.LIST_CAPACITY(CAP)) i_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .req(req),
        .empty(empty), .pop(pop), .rsp(rsp)
    );

    initial clk = 0;
    always #6 clk = ~clk;

    initial
    begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic bit y_hit(rfsj_pkg::in_item_t a, rfsj_pkg::in_item_t b);
        return !(a.box_max_y < b.box_min_y || a.box_min_y > b.box_max_y);
    endfunction

    function automatic rfsj_pkg::out_item_t mk_out(logic [1:0] st, logic [15:0] l,
                                                   logic [15:0] r);
        rfsj_pkg::out_item_t o;
        o.status = st;
        o.left_id = l;
        o.right_id = r;
        return o;
    endfunction

    function automatic rfsj_pkg::out_item_t sweep_step(rfsj_pkg::in_item_t it);
        rfsj_pkg::in_item_t outer;
        int k;
        if (it.mode == rfsj_pkg::MODE_CLEAR)
        begin
            left_cnt = 0;
            right_cnt = 0;
            left_cur = 0;
            right_cur = 0;
            inner_cur = 0;
            phase = rfsj_pkg::PHASE_IDLE;
            return mk_out(rfsj_pkg::STATUS_ACCEPTED, 0, 0);
        end
        if (it.mode != rfsj_pkg::MODE_NEXT)
        begin
            left_cur = 0;
            right_cur = 0;
            inner_cur = 0;
            phase = rfsj_pkg::PHASE_IDLE;
            if (it.mode == rfsj_pkg::MODE_LOAD_LEFT)
            begin
                if (left_cnt >= CAP)
                    return mk_out(rfsj_pkg::STATUS_FULL, 0, 0);
                left_list[left_cnt[IW-1:0]] = it;
                left_cnt++;
            end
            else
            begin
                if (right_cnt >= CAP)
                    return mk_out(rfsj_pkg::STATUS_FULL, 0, 0);
                right_list[right_cnt[IW-1:0]] = it;
                right_cnt++;
            end
            return mk_out(rfsj_pkg::STATUS_ACCEPTED, 0, 0);
        end
        forever
        begin
            if (phase == rfsj_pkg::PHASE_DONE)
                return mk_out(rfsj_pkg::STATUS_DONE, 0, 0);
            if (phase == rfsj_pkg::PHASE_IDLE)
            begin
                if (left_cur >= left_cnt || right_cur >= right_cnt)
                begin
                    phase = rfsj_pkg::PHASE_DONE;
                    continue;
                end
                if (left_list[left_cur[IW-1:0]].box_min_x <=
                    right_list[right_cur[IW-1:0]].box_min_x)
                begin
                    phase = rfsj_pkg::PHASE_LEFT;
                    inner_cur = right_cur;
                end
                else
                begin
                    phase = rfsj_pkg::PHASE_RIGHT;
                    inner_cur = left_cur;
                end
            end
            if (phase == rfsj_pkg::PHASE_LEFT)
            begin
                outer = left_list[left_cur[IW-1:0]];
                while (inner_cur < right_cnt &&
                       outer.box_max_x >= right_list[inner_cur[IW-1:0]].box_min_x)
                begin
                    k = inner_cur;
                    inner_cur++;
                    if (y_hit(outer, right_list[k[IW-1:0]]))
                        return mk_out(rfsj_pkg::STATUS_PAIR, outer.box_id,
                                      right_list[k[IW-1:0]].box_id);
                end
                left_cur++;
                phase = rfsj_pkg::PHASE_IDLE;
            end
            else
            begin
                outer = right_list[right_cur[IW-1:0]];
                while (inner_cur < left_cnt &&
                       outer.box_max_x >= left_list[inner_cur[IW-1:0]].box_min_x)
                begin
                    k = inner_cur;
                    inner_cur++;
                    if (y_hit(outer, left_list[k[IW-1:0]]))
                        return mk_out(rfsj_pkg::STATUS_PAIR, left_list[k[IW-1:0]].box_id,
                                      outer.box_id);
                end
                right_cur++;
                phase = rfsj_pkg::PHASE_IDLE;
            end
        end
    endfunction

    function automatic rfsj_pkg::in_item_t mk_item(logic [1:0] m, logic [15:0] x0,
                                                   logic [15:0] y0, logic [15:0] x1,
                                                   logic [15:0] y1, logic [15:0] id);
        rfsj_pkg::in_item_t it;
        it.mode = m;
        it.box_min_x = x0;
        it.box_min_y = y0;
        it.box_max_x = x1;
        it.box_max_y = y1;
        it.box_id = id;
        return it;
    endfunction

    function automatic row_t mk_row(rfsj_pkg::in_item_t it, logic has, logic [1:0] st);
        row_t r;
        r.item = it;
        r.has_exp = has;
        r.exp = mk_out(st, 0, 0);
        return r;
    endfunction

    function automatic void add_row(row_t r);
        dir_rows = {dir_rows, r};
    endfunction

    function automatic rfsj_pkg::in_item_t next_item();
        return mk_item(rfsj_pkg::MODE_NEXT, 0, 0, 0, 0, 0);
    endfunction

    task automatic send_item(input rfsj_pkg::in_item_t it, input logic has_exp,
                             input rfsj_pkg::out_item_t exp, output logic [1:0] st);
        rfsj_pkg::out_item_t pred;
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 16);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        req <= it;
        do
            @(posedge clk);
        while (full);
        pred = sweep_step(it);
        expected_q = {expected_q, (has_exp ? exp : pred)};
        st = pred.status;
        items_sent++;
    endtask

    task automatic send(input rfsj_pkg::in_item_t it, output logic [1:0] st);
        send_item(it, 1'b0, '0, st);
    endtask

    task automatic load_box(input logic [1:0] m, input logic [15:0] x0);
        logic [16:0] x1;
        logic [15:0] y0, y1;
        logic [1:0] st;
        x1 = {1'b0, x0} + 17'($urandom_range(0, 60));
        if (x1 > 17'hFFFF)
            x1 = 17'hFFFF;
        if ($urandom_range(0, 5) == 0)
        begin
            y0 = 16'($urandom);
            y1 = 16'($urandom);
        end
        else
        begin
            y0 = 16'($urandom_range(0, 200));
            y1 = y0 + 16'($urandom_range(0, 80));
        end
        if ($urandom_range(0, 15) == 0)
            x1 = (x0 > 16'd5) ? {1'b0, x0 - 16'd5} : 17'd0;
        send(mk_item(m, x0, y0, x1[15:0], y1, 16'($urandom)), st);
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (expected_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("Unexpected result: %p", rsp);
                end
                else
                begin
                    if (rsp !== expected_q[0])
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("Mismatch: expected %p, got %p", expected_q[0], rsp);
                    end
                    if (rsp.status == rfsj_pkg::STATUS_PAIR)
                        pairs_seen++;
                    if (rsp.status == rfsj_pkg::STATUS_FULL)
                        dropped_seen++;
                    void'(expected_q.pop_front());
                end
            end
        end
    end

    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                pop <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 0;
                hold = 300;
                pop <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                hold = $urandom_range(1, 16) - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    initial
    begin
        logic [1:0] st;
        logic [15:0] xl, xr;
        int nl, nr, guard, i;
        push = 0;
        pop = 0;
        req = '0;
        rst_n = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(mk_row(next_item(), 1, rfsj_pkg::STATUS_DONE));
        add_row(mk_row(mk_item(rfsj_pkg::MODE_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               16'hFFFF, 16'hFFFF), 1, rfsj_pkg::STATUS_ACCEPTED));
        add_row(mk_row(mk_item(rfsj_pkg::MODE_LOAD_LEFT, 0, 0, 16'hFFFF, 16'hFFFF,
                               16'hFFFF), 1, rfsj_pkg::STATUS_ACCEPTED));
        add_row(mk_row(mk_item(rfsj_pkg::MODE_LOAD_RIGHT, 0, 0, 0, 0, 0),
                       1, rfsj_pkg::STATUS_ACCEPTED));
        add_row(mk_row(next_item(), 0, 0));
        add_row(mk_row(next_item(), 0, 0));
        add_row(mk_row(mk_item(rfsj_pkg::MODE_LOAD_RIGHT, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               16'hFFFF, 16'h8001), 1, rfsj_pkg::STATUS_ACCEPTED));
        add_row(mk_row(next_item(), 0, 0));
        add_row(mk_row(next_item(), 0, 0));
        add_row(mk_row(next_item(), 0, 0));
        add_row(mk_row(mk_item(rfsj_pkg::MODE_LOAD_LEFT, 100, 300, 50, 200, 16'h1234),
                       1, rfsj_pkg::STATUS_ACCEPTED));
        add_row(mk_row(mk_item(rfsj_pkg::MODE_LOAD_RIGHT, 5, 0, 120, 16'hFFFF, 16'h5678),
                       1, rfsj_pkg::STATUS_ACCEPTED));
        for (i = 0; i < 5; i++)
            add_row(mk_row(next_item(), 0, 0));
        add_row(mk_row(mk_item(rfsj_pkg::MODE_CLEAR, 0, 0, 0, 0, 0),
                       1, rfsj_pkg::STATUS_ACCEPTED));
        add_row(mk_row(next_item(), 1, rfsj_pkg::STATUS_DONE));
        add_row(mk_row(mk_item(rfsj_pkg::MODE_LOAD_RIGHT, 10, 5, 30, 9, 16'h00AA),
                       1, rfsj_pkg::STATUS_ACCEPTED));
        add_row(mk_row(mk_item(rfsj_pkg::MODE_LOAD_LEFT, 20, 9, 25, 12, 16'h0055),
                       1, rfsj_pkg::STATUS_ACCEPTED));
        for (i = 0; i < 3; i++)
            add_row(mk_row(next_item(), 0, 0));
        foreach (dir_rows[j])
            send_item(dir_rows[j].item, dir_rows[j].has_exp, dir_rows[j].exp, st);

        while (items_sent < 900)
        begin
            if (items_sent > 780)
                calm = 1;
            if ($urandom_range(0, 9) == 0)
            begin
                send(mk_item(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom)), st);
                continue;
            end
            send(mk_item(rfsj_pkg::MODE_CLEAR, 0, 0, 0, 0, 0), st);
            nl = $urandom_range(0, 12);
            nr = $urandom_range(0, 12);
            xl = 16'($urandom_range(0, 65000));
            xr = xl + 16'($urandom_range(0, 30));
            while (nl > 0 || nr > 0)
            begin
                if (nl > 0 && (nr == 0 || $urandom_range(0, 1)))
                begin
                    load_box(rfsj_pkg::MODE_LOAD_LEFT, xl);
                    xl = (xl > 16'd65500) ? xl : xl + 16'($urandom_range(0, 40));
                    nl--;
                end
                else
                begin
                    load_box(rfsj_pkg::MODE_LOAD_RIGHT, xr);
                    xr = (xr > 16'd65500) ? xr : xr + 16'($urandom_range(0, 40));
                    nr--;
                end
            end
            guard = 0;
            do
            begin
                send(mk_item(rfsj_pkg::MODE_NEXT, 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom), 16'($urandom)), st);
                guard++;
                if ($urandom_range(0, 19) == 0)
                    load_box(2'($urandom_range(rfsj_pkg::MODE_LOAD_LEFT,
                                               rfsj_pkg::MODE_LOAD_RIGHT)), 16'hFFF0);
            end
            while (st != rfsj_pkg::STATUS_DONE && guard < 400);
            send(next_item(), st);
            if (items_sent > 300 && dropped_seen == 0 && expected_q.size() < 4)
            begin
                hold_request = 1;
                send(mk_item(rfsj_pkg::MODE_CLEAR, 0, 0, 0, 0, 0), st);
                for (i = 0; i < CAP + 3; i++)
                    load_box(rfsj_pkg::MODE_LOAD_LEFT, i[15:0]);
                load_box(rfsj_pkg::MODE_LOAD_RIGHT, 16'd40);
                load_box(rfsj_pkg::MODE_LOAD_RIGHT, 16'd200);
                for (i = 0; i < 6; i++)
                    send(next_item(), st);
                dropped_seen = 1;
            end
        end
        push <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("Covered %0d items: clears, left and right loads, sweeps and noise,", items_sent);
        $display("with %0d pairs reported and a full list overflowed once.", pairs_seen);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### rect_forward_scan_join_unit.f
sv/rfsj_pkg.sv
sv/rfsj_fifo.sv
sv/rfsj_front.sv
sv/rfsj_back.sv
sv/rect_forward_scan_join_unit.sv
tb/sv/testbench.sv
